// ----- rtl/b64lw_pkg.sv -----
// shared types, constants and the alphabet lookup for the base64 line-wrapping encoder
package b64lw_pkg;

  localparam int unsigned MAX_LINE_LIMIT_DEF = 1023;
  localparam int unsigned MAX_RESULTS        = 4;

  localparam logic [10:0] COUNT_MAX   = 11'd2047;
  localparam logic [7:0]  CHAR_PAD    = 8'h3d;  // '='
  localparam logic [7:0]  CHAR_CR     = 8'h0d;
  localparam logic [7:0]  CHAR_LF     = 8'h0a;
  localparam logic [7:0]  CODE_MASK   = 8'h3f;
  localparam logic [7:0]  HELD_MASK_1 = 8'h30;
  localparam logic [7:0]  HELD_MASK_2 = 8'h3c;

  typedef enum logic [1:0] {
    PHASE_FIRST  = 2'd0,
    PHASE_SECOND = 2'd1,
    PHASE_THIRD  = 2'd2,
    PHASE_UNUSED = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_item_t;

  // standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [7:0] b64_char(input logic [5:0] code);
    logic [7:0] ch;
    if (code < 6'd26) begin
      ch = 8'h41 + {2'b00, code};
    end else if (code < 6'd52) begin
      ch = 8'h61 + {2'b00, code - 6'd26};
    end else if (code < 6'd62) begin
      ch = 8'h30 + {2'b00, code - 6'd52};
    end else if (code == 6'd62) begin
      ch = 8'h2b;
    end else begin
      ch = 8'h2f;
    end
    return ch;
  endfunction

endpackage

// ----- rtl/base64_encoder_line_wrap.sv -----
// top level of the streaming base64 encoder with CR LF line wrapping
// the first character of an item is valid in the cycle after the item is accepted
// one character per cycle while out_ready_i is high; an item yields 1 to 4 characters
// a new item is taken in the cycle its predecessor's final character leaves
// reset (rst_ni low, asynchronous) clears group phase, held bits, line count, max_line
//   and empties the character buffer
module base64_encoder_line_wrap #(
  parameter int unsigned MAX_LINE_LIMIT = b64lw_pkg::MAX_LINE_LIMIT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [9:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  b64lw_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output b64lw_pkg::out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(b64lw_pkg::MAX_RESULTS + 1);

  // encoder state
  b64lw_pkg::phase_e phase_q, phase_d;
  logic [5:0]        held_q, held_d;
  logic [10:0]       line_count_q, line_count_d;
  logic [9:0]        max_line_q;

  // result buffer, head entry at index 0 drives the output
  b64lw_pkg::out_item_t buf_q [b64lw_pkg::MAX_RESULTS];
  b64lw_pkg::out_item_t buf_d [b64lw_pkg::MAX_RESULTS];
  logic [CntW-1:0]      cnt_q, cnt_d;

  logic        in_acc, out_acc;
  logic [7:0]  b;
  logic        last;
  logic [9:0]  limit;
  logic [11:0] count_sum;
  logic [10:0] count_sat;
  logic        wrap;
  logic [5:0]  held_new;
  logic [7:0]  chars [b64lw_pkg::MAX_RESULTS];
  logic [CntW-1:0] n_chars;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = buf_q[0];
  assign out_acc     = out_valid_o && out_ready_i;
  // take a new item once the buffer is empty or its final character leaves now
  assign in_ready_o  = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;

  assign b    = in_item_i.data_byte;
  assign last = in_item_i.last_byte;

  // clamp the configured line length to the build limit
  always_comb begin
    if (32'(max_line_q) > 32'(MAX_LINE_LIMIT)) begin
      limit = 10'(MAX_LINE_LIMIT);
    end else begin
      limit = max_line_q;
    end
  end

  // line count after a complete group, saturating
  assign count_sum = {1'b0, line_count_q} + 12'd4;
  assign count_sat = count_sum[11] ? b64lw_pkg::COUNT_MAX : count_sum[10:0];
  assign wrap      = (limit != '0) && (count_sat >= {1'b0, limit});

  // characters for one item and the state it leaves
  always_comb begin
    phase_d      = phase_q;
    held_d       = held_q;
    line_count_d = line_count_q;
    held_new     = '0;
    n_chars      = CntW'(1);
    for (int i = 0; i < b64lw_pkg::MAX_RESULTS; i++) begin
      chars[i] = b64lw_pkg::CHAR_PAD;
    end
    case (phase_q)
      b64lw_pkg::PHASE_SECOND: begin
        held_new = 6'((b << 2) & b64lw_pkg::HELD_MASK_2);
        chars[0] = b64lw_pkg::b64_char(held_q | {2'b00, b[7:4]});
        chars[1] = b64lw_pkg::b64_char(held_new);
        held_d   = held_new;
        phase_d  = b64lw_pkg::PHASE_THIRD;
        n_chars  = last ? CntW'(3) : CntW'(1);
      end
      b64lw_pkg::PHASE_THIRD: begin
        chars[0] = b64lw_pkg::b64_char(held_q | {4'b0000, b[7:6]});
        chars[1] = b64lw_pkg::b64_char(b[5:0]);
        chars[2] = b64lw_pkg::CHAR_CR;
        chars[3] = b64lw_pkg::CHAR_LF;
        held_d   = '0;
        phase_d  = b64lw_pkg::PHASE_FIRST;
        n_chars  = wrap ? CntW'(4) : CntW'(2);
        line_count_d = wrap ? '0 : count_sat;
      end
      default: begin
        // first byte of a group; the unused phase code acts the same
        held_new = 6'((b << 4) & b64lw_pkg::HELD_MASK_1);
        chars[0] = b64lw_pkg::b64_char(b[7:2]);
        chars[1] = b64lw_pkg::b64_char(held_new);
        held_d   = held_new;
        phase_d  = b64lw_pkg::PHASE_SECOND;
        n_chars  = last ? CntW'(4) : CntW'(1);
      end
    endcase
    // end of message returns to the reset state
    if (last) begin
      phase_d      = b64lw_pkg::PHASE_FIRST;
      held_d       = '0;
      line_count_d = '0;
    end
  end

  // buffer load on accept, shift by one on each character taken
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < b64lw_pkg::MAX_RESULTS; i++) begin
      buf_d[i] = buf_q[i];
    end
    if (in_acc) begin
      cnt_d = n_chars;
      for (int i = 0; i < b64lw_pkg::MAX_RESULTS; i++) begin
        buf_d[i].out_char = chars[i];
        buf_d[i].out_last = last && (CntW'(i + 1) == n_chars);
      end
    end else if (out_acc) begin
      cnt_d = cnt_q - CntW'(1);
      for (int i = 0; i < b64lw_pkg::MAX_RESULTS - 1; i++) begin
        buf_d[i] = buf_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= b64lw_pkg::PHASE_FIRST;
      held_q       <= '0;
      line_count_q <= '0;
      max_line_q   <= '0;
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        max_line_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        phase_q      <= phase_d;
        held_q       <= held_d;
        line_count_q <= line_count_d;
      end
      cnt_q <= cnt_d;
    end
  end

  // payload buffer, no reset needed
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < b64lw_pkg::MAX_RESULTS; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

  // an item is only taken when nothing but a departing final character is buffered
  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_acc))
    else $error("item accepted while buffer still held characters");

  // end of message leaves the encoder in its reset state
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last) |=> (phase_q == b64lw_pkg::PHASE_FIRST) && (held_q == '0)
                         && (line_count_q == '0))
    else $error("encoder state not cleared after final byte");

  // buffer never holds more than one item's characters
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(b64lw_pkg::MAX_RESULTS))
    else $error("character count out of range");

  // a flagged final character is the only one left in the buffer
  a_last_is_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.out_last) |-> (cnt_q == CntW'(1)))
    else $error("final character is not the buffer tail");

endmodule
